// ===== src/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the phased renormalized convolver.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int KERNEL_MAX = 64;
  localparam int ADDR_W     = $clog2(KERNEL_MAX);
  localparam int KLEN_W     = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 6;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = PROD_W + ADDR_W;
  localparam int NORM_W     = SAMPLE_W + ADDR_W;
  localparam int FRAC_W     = 15;
  localparam int DIVD_W     = ACC_W + FRAC_W;
  localparam int RES_W      = 48;
  localparam int IDX_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RENORM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KLEN   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } prc_state_e;

  typedef struct packed {
    logic                       tap_we;
    logic                       smp_we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic                       clr;
    logic                       issue;
    logic [ADDR_W-1:0]          tap_addr;
    logic [ADDR_W-1:0]          smp_addr;
  } prc_mac_ctrl_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [IDX_W-1:0]        series_index;
    logic                    zero_norm;
    logic                    last_of_run;
  } prc_out_t;

endpackage

// ===== src/prc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface prc_in_if;
  import prc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ADDR_W-1:0]          tap_index;
  logic signed [SAMPLE_W-1:0] value;
  logic                       last_sample;
  modport source (output valid, cmd, tap_index, value, last_sample, input ready);
  modport sink   (input valid, cmd, tap_index, value, last_sample, output ready);
endinterface

interface prc_out_if;
  import prc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;
  logic [IDX_W-1:0]        series_index;
  logic                    zero_norm;
  logic                    last_of_run;
  modport source (output valid, result, series_index, zero_norm, last_of_run, input ready);
  modport sink   (input valid, result, series_index, zero_norm, last_of_run, output ready);
endinterface

interface prc_cfg_if;
  import prc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/prc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_mac
// Tap store, sample ring and the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module prc_mac
  import prc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  prc_mac_ctrl_t            ctrl_i,
  output logic signed [ACC_W-1:0]  acc_o,
  output logic signed [NORM_W-1:0] norm_o,
  output logic                     busy_o
);

  logic signed [SAMPLE_W-1:0] taps_mem [KERNEL_MAX];
  logic signed [SAMPLE_W-1:0] ring_mem [KERNEL_MAX];
  logic signed [SAMPLE_W-1:0] tap_rd_q, smp_rd_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [NORM_W-1:0]   norm_q;
  logic                       v1_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_we) taps_mem[ctrl_i.waddr] <= ctrl_i.wdata;
    if (ctrl_i.smp_we) ring_mem[ctrl_i.waddr] <= ctrl_i.wdata;
    tap_rd_q <= taps_mem[ctrl_i.tap_addr];
    smp_rd_q <= ring_mem[ctrl_i.smp_addr];
    prod_q   <= smp_rd_q * tap_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      acc_q  <= '0;
      norm_q <= '0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      if (ctrl_i.clr) begin
        acc_q  <= '0;
        norm_q <= '0;
      end else begin
        if (v1_q) norm_q <= norm_q + NORM_W'(tap_rd_q);
        if (v2_q) acc_q  <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign norm_o = norm_q;
  assign busy_o = v1_q | v2_q;

endmodule

// ===== src/prc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prc_div
  import prc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [NORM_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] quot_q;
  logic [NORM_W-1:0] rem_q, dvs_q;
  logic [NORM_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quot_q[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? NORM_W'(rem_sh - {1'b0, dvs_q}) : NORM_W'(rem_sh);
      quot_q <= {quot_q[DIVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/phased_renormalized_convolver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phased_renormalized_convolver_core
// FIR convolver with look-ahead phase and optional edge renormalization.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat loads a tap (cmd 0) or delivers a sample (cmd 1).
//   out_o : one beat per convolved output, in order of series index.
//   cfg_i : register writes (phase, renormalize, kernel length); always ready,
//           to be written only while the core is idle.
// Timing:
//   A sample is taken only when the core is idle; each output it causes
//   walks the used taps through one shared multiplier, one tap per cycle,
//   after a setup step and before the drain and output steps; in
//   renormalize mode with a nonzero tap sum the bit-serial divider runs
//   between drain and output. The last sample of a series emits up to
//   phase + 1 outputs back to back in that manner.
// Reset clears the sample count, ring pointer and handshakes and presets the
// registers; taps and samples stay undefined until written. A stalled receiver
// holds the result in the output register and the sequencer waits for it.
// ----------------------------------------------------------------------------
module phased_renormalized_convolver_core
  import prc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  prc_in_if.sink     in_i,
  prc_out_if.source  out_o,
  prc_cfg_if.sink    cfg_i
);

  prc_state_e state_q, state_d;

  logic [PHASE_W-1:0]  phase_q;
  logic                renorm_q;
  logic [KLEN_W-1:0]   klen_q, klen_eff;
  logic [ADDR_W-1:0]   head_q, base_q, d_q;
  logic [IDX_W-1:0]    count_q, n_q, t_q;
  logic                lastmode_q;
  logic [KLEN_W-1:0]   i_q, hi_q, hi_d;
  logic [IDX_W+1:0]    pp1;
  logic                zflag_q;
  logic signed [RES_W-1:0] res_q;
  logic                out_valid_q;
  prc_out_t            out_q;
  logic                in_acc, slot_free, done_run;

  prc_mac_ctrl_t           mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [NORM_W-1:0] norm;
  logic                     mac_busy;

  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_quot, dvd_mag;
  logic [NORM_W-1:0] dvs_mag;
  logic              q_neg;
  logic [DIVD_W-1:0] q_abs;
  logic signed [RES_W-1:0] q_sat;

  localparam logic [DIVD_W-1:0] POS_LIM = DIVD_W'({1'b0, {(RES_W-1){1'b1}}});
  localparam logic [DIVD_W-1:0] NEG_LIM = DIVD_W'({1'b1, {(RES_W-1){1'b0}}});

  assign klen_eff  = (klen_q > KLEN_W'(KERNEL_MAX)) ? KLEN_W'(KERNEL_MAX) : klen_q;
  assign in_acc    = in_i.valid & in_i.ready;
  assign slot_free = ~out_valid_q | out_o.ready;
  assign done_run  = ~lastmode_q | (t_q == n_q);
  assign pp1       = (IDX_W+2)'(t_q) + (IDX_W+2)'(phase_q) + (IDX_W+2)'(1);
  assign hi_d      = (pp1 < (IDX_W+2)'(klen_eff)) ? KLEN_W'(pp1) : klen_eff;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mac_ctrl  = '0;
    mac_ctrl.tap_we   = in_acc & ~in_i.cmd;
    mac_ctrl.smp_we   = in_acc & in_i.cmd;
    mac_ctrl.waddr    = in_i.cmd ? head_q : in_i.tap_index;
    mac_ctrl.wdata    = in_i.value;
    mac_ctrl.tap_addr = i_q[ADDR_W-1:0];
    mac_ctrl.smp_addr = base_q + d_q - i_q[ADDR_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.cmd && (in_i.last_sample || count_q >= IDX_W'(phase_q))) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        mac_ctrl.clr = 1'b1;
        state_d = (KLEN_W'(d_q) < hi_d) ? ST_MAC : ST_DRAIN;
      end
      ST_MAC: begin
        mac_ctrl.issue = 1'b1;
        if (i_q + 1'b1 >= hi_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          if (renorm_q && norm != '0) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) state_d = done_run ? ST_IDLE : ST_SETUP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      renorm_q    <= 1'b1;
      klen_q      <= KLEN_W'(KERNEL_MAX);
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_PHASE:  phase_q  <= cfg_i.data[PHASE_W-1:0];
          CFG_RENORM: renorm_q <= cfg_i.data[0];
          CFG_KLEN:   klen_q   <= cfg_i.data[KLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_i.cmd) begin
        head_q <= head_q + 1'b1;
        if (in_i.last_sample)        count_q <= '0;
        else if (count_q != '1)      count_q <= count_q + 1'b1;
      end
      if (out_o.ready) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && slot_free) out_valid_q <= 1'b1;
    end
  end

  assign dvd_mag = acc[ACC_W-1] ? DIVD_W'(-acc) << FRAC_W : DIVD_W'(acc) << FRAC_W;
  assign dvs_mag = norm[NORM_W-1] ? NORM_W'(-norm) : NORM_W'(norm);
  assign q_neg   = acc[ACC_W-1] ^ norm[NORM_W-1];
  assign q_abs   = div_quot;

  always_comb begin
    if (!q_neg && q_abs > POS_LIM)     q_sat = RES_W'(POS_LIM);
    else if (q_neg && q_abs > NEG_LIM) q_sat = RES_W'(NEG_LIM);
    else if (q_neg)                    q_sat = RES_W'(-q_abs);
    else                               q_sat = RES_W'(q_abs);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.cmd) begin
          n_q        <= count_q;
          base_q     <= head_q;
          lastmode_q <= in_i.last_sample;
          if (count_q >= IDX_W'(phase_q)) begin
            t_q <= count_q - IDX_W'(phase_q);
            d_q <= '0;
          end else begin
            t_q <= '0;
            d_q <= ADDR_W'(phase_q) - count_q[ADDR_W-1:0];
          end
        end
      end
      ST_SETUP: begin
        i_q  <= KLEN_W'(d_q);
        hi_q <= hi_d;
      end
      ST_MAC: i_q <= i_q + 1'b1;
      ST_DRAIN: begin
        if (!mac_busy) begin
          zflag_q <= renorm_q && norm == '0;
          res_q   <= renorm_q ? '0 : RES_W'(acc);
        end
      end
      ST_DIV: begin
        if (div_done) res_q <= q_sat;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_q.result       <= res_q;
          out_q.series_index <= t_q;
          out_q.zero_norm    <= zflag_q;
          out_q.last_of_run  <= done_run;
          t_q <= t_q + 1'b1;
          d_q <= d_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result       = out_q.result;
  assign out_o.series_index = out_q.series_index;
  assign out_o.zero_norm    = out_q.zero_norm;
  assign out_o.last_of_run  = out_q.last_of_run;

  prc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .acc_o  (acc),
    .norm_o (norm),
    .busy_o (mac_busy)
  );

  prc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_mag),
    .divisor_i  (dvs_mag),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

// ===== tb/tb_phased_renormalized_convolver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phased_renormalized_convolver_core
// Drives tap loads and sample series into the convolver under several
// register settings and idle and stall patterns. Every result is checked
// field by field against a behavioral FIR model with phase look-ahead,
// renormalization and 48-bit saturation.
// ----------------------------------------------------------------------------
module tb_phased_renormalized_convolver_core;
  import prc_pkg::*;

  typedef struct {
    logic                       cmd;
    logic [ADDR_W-1:0]          tap_index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_sample;
  } prc_item_t;

  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam longint RES_MAX  = 64'sh7FFF_FFFF_FFFF;
  localparam longint RES_MIN  = -64'sh8000_0000_0000;
  localparam int LIMIT_CYCLES = 3000000;

  logic clk_i;
  logic rst_ni;

  prc_in_if  in_if ();
  prc_out_if out_if ();
  prc_cfg_if cfg_if ();

  phased_renormalized_convolver_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  prc_item_t pending_items[$];
  prc_out_t  expected_outputs[$];

  // model state
  int               tap_mem[KERNEL_MAX];
  int               sample_mem[KERNEL_MAX];
  logic [IDX_W-1:0] sample_cnt;
  logic [ADDR_W-1:0] ring_wr;
  int               phase_reg;
  logic             renorm_reg;
  int               klen_reg;

  int  idle_pct;
  int  stall_pct;
  int  mismatches;
  int  cycle_cnt;
  int  samples_sent;
  logic in_fire;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic prc_out_t conv_output(longint unsigned t, longint unsigned n,
                                           logic last);
    prc_out_t        o;
    longint unsigned p;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned back;
    longint          acc;
    longint          norm;
    longint          r;
    logic [ADDR_W-1:0] pos;
    p    = t + phase_reg;
    lo   = (p > n) ? p - n : 0;
    hi   = (klen_reg < p + 1) ? klen_reg : p + 1;
    acc  = 0;
    norm = 0;
    o.zero_norm = 1'b0;
    for (longint unsigned i = lo; i < hi; i++) begin
      back = n - (p - i);
      pos  = ring_wr - 6'd1 - back[ADDR_W-1:0];
      acc  += longint'(sample_mem[pos]) * longint'(tap_mem[i]);
      norm += tap_mem[i];
    end
    if (renorm_reg) begin
      if (norm == 0) begin
        r = 0;
        o.zero_norm = 1'b1;
      end else begin
        r = (acc * 32768) / norm;
      end
    end else begin
      r = acc;
    end
    if (r > RES_MAX) r = RES_MAX;
    if (r < RES_MIN) r = RES_MIN;
    o.result       = r[RES_W-1:0];
    o.series_index = t[IDX_W-1:0];
    o.last_of_run  = last;
    return o;
  endfunction

  task automatic conv_accept(prc_item_t it);
    longint unsigned n;
    longint unsigned first;
    if (it.cmd == CMD_TAP) begin
      tap_mem[it.tap_index] = it.value;
      return;
    end
    sample_mem[ring_wr] = it.value;
    ring_wr = ring_wr + 1'b1;
    n = sample_cnt;
    if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;
    if (!it.last_sample) begin
      if (n >= phase_reg) expected_outputs.push_back(conv_output(n - phase_reg, n, 1'b1));
    end else begin
      first = (n >= phase_reg) ? n - phase_reg : 0;
      for (longint unsigned t = first; t <= n; t++)
        expected_outputs.push_back(conv_output(t, n, t == n));
      sample_cnt = '0;
    end
  endtask

  // monitor: input beats feed the model, output beats are checked
  always @(posedge clk_i) begin
    prc_item_t it;
    prc_out_t  got;
    prc_out_t  exp;
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_PHASE:  phase_reg  = cfg_if.data[PHASE_W-1:0];
          CFG_RENORM: renorm_reg = cfg_if.data[0];
          CFG_KLEN:   klen_reg   = (cfg_if.data > KERNEL_MAX) ? KERNEL_MAX : cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        it.cmd         = in_if.cmd;
        it.tap_index   = in_if.tap_index;
        it.value       = in_if.value;
        it.last_sample = in_if.last_sample;
        conv_accept(it);
      end
      if (out_if.valid && out_if.ready) begin
        got.result       = out_if.result;
        got.series_index = out_if.series_index;
        got.zero_norm    = out_if.zero_norm;
        got.last_of_run  = out_if.last_of_run;
        if (expected_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          exp = expected_outputs.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    prc_item_t it;
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
      if (!in_if.valid || in_fire) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          it = pending_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.cmd         <= it.cmd;
          in_if.tap_index   <= it.tap_index;
          in_if.value       <= it.value;
          in_if.last_sample <= it.last_sample;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL phased_renormalized_convolver_core");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_tap(int idx, logic signed [SAMPLE_W-1:0] v);
    prc_item_t it;
    it.cmd = CMD_TAP;
    it.tap_index = ADDR_W'(idx);
    it.value = v;
    it.last_sample = 1'($urandom_range(1));
    pending_items.push_back(it);
  endtask

  task automatic queue_series(int len, logic end_last);
    prc_item_t it;
    for (int k = 0; k < len; k++) begin
      it.cmd = CMD_SAMPLE;
      it.tap_index = ADDR_W'($urandom);
      it.value = pick_value();
      it.last_sample = end_last && (k == len - 1);
      pending_items.push_back(it);
      samples_sent++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_outputs.size() != 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_pacing(int sel);
    case (sel % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 70; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  task automatic run_setting(int ph, int rn, int kl);
    wait_quiet();
    write_reg(CFG_PHASE, ph);
    write_reg(CFG_RENORM, rn);
    write_reg(CFG_KLEN, kl);
  endtask

  initial begin
    int round;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TAP;
    in_if.tap_index = '0;
    in_if.value = '0;
    in_if.last_sample = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_PHASE;
    cfg_if.data = '0;
    in_fire = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    cycle_cnt = 0;
    samples_sent = 0;
    sample_cnt = '0;
    ring_wr = '0;
    phase_reg = 0;
    renorm_reg = 1'b1;
    klen_reg = KERNEL_MAX;
    foreach (tap_mem[i]) tap_mem[i] = 0;
    foreach (sample_mem[i]) sample_mem[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: all taps written, extremes first
    queue_tap(0, 16'sh7FFF);
    queue_tap(1, 16'sh8000);
    for (int i = 2; i < KERNEL_MAX; i++) queue_tap(i, pick_value());
    run_setting(0, 1, KERNEL_MAX);
    queue_series(3, 1'b1);
    run_setting(0, 0, 1);
    queue_series(4, 1'b1);
    run_setting(2, 0, 0);
    queue_series(3, 1'b1);
    queue_series(1, 1'b1);
    // zero tap sum under renormalization
    queue_tap(0, 16'sh4000);
    queue_tap(1, -16'sh4000);
    run_setting(1, 1, 2);
    queue_series(3, 1'b1);
    run_setting(63, 1, 127);
    queue_series(4, 1'b0);
    queue_series(2, 1'b1);

    round = 0;
    while (samples_sent < 30) begin
      set_pacing(round);
      run_setting(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(4),
                  $urandom_range(1),
                  ($urandom_range(7) == 0) ? $urandom_range(64, 127) : $urandom_range(8));
      for (int k = $urandom_range(3); k > 0; k--) queue_tap($urandom_range(63), pick_value());
      for (int k = $urandom_range(1, 3); k > 0; k--)
        queue_series($urandom_range(1, 10), $urandom_range(9) != 0);
      round++;
    end
    // one longer series over the full kernel
    run_setting(1, 0, KERNEL_MAX);
    queue_series(40, 1'b1);
    wait_quiet();

    if (mismatches == 0) begin
      $display("PASS phased_renormalized_convolver_core");
    end else begin
      $display("FAIL phased_renormalized_convolver_core");
    end
    $finish;
  end

endmodule
